// ===== design/nem_pkg.sv =====
// Shared types and constants for the epsilon-NFA matcher.
package nem_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_START_STATE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_MASK    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EPSILON_CODE = 2'd2;

    localparam logic [1:0] KIND_ADD     = 2'd0;
    localparam logic [1:0] KIND_BEGIN   = 2'd1;
    localparam logic [1:0] KIND_CONSUME = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [4:0] src_state;
        logic [4:0] dst_state;
        logic [7:0] symbol;
    } in_item_t;

    typedef struct packed {
        logic        accepted;
        logic [31:0] active_set;
        logic        dead;
    } out_item_t;

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_ADD_RD = 7'b0000100,
        ST_ADD_WR = 7'b0001000,
        ST_MOVE   = 7'b0010000,
        ST_CLOSE  = 7'b0100000,
        ST_FINISH = 7'b1000000
    } state_t;

endpackage

// ===== design/nem_ram.sv =====
// Generic simple dual-port RAM with registered read.
module nem_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/nfa_epsilon_matcher_core.sv =====
// Epsilon-NFA matcher top level: control, worklist walker and result register.
//
// Transitions live in two RAMs: a move table of NUM_STATES * 2**SYMBOL_BITS rows
// and an epsilon table of NUM_STATES rows, each row a destination state mask.
// After reset the block sweeps both tables to zero, one row per cycle, with
// s_ready low; config writes are taken meanwhile. One transaction is processed
// at a time. An add reads the addressed row, writes it back with the new
// destination bit and then posts the result; an add with an out-of-range state
// skips the write, and an unused kind goes straight to the result. A begin walks
// the epsilon closure of the start state; a consume first walks the active
// states through the move table and then closes the new set over epsilon
// edges. Both walks go through the single read port of each table: every
// active state costs one move-row read and every state entering the closure
// costs one epsilon-row read, and the walker waits whenever the worklist runs
// dry while a row read is still in flight. The finished result sits in an
// output register, so the next transaction is accepted while it waits.
module nfa_epsilon_matcher_core #(
    parameter int NUM_STATES  = 32,
    parameter int SYMBOL_BITS = 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [nem_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [nem_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  nem_pkg::in_item_t                s_item,
    output logic                             m_valid,
    input  logic                             m_ready,
    output nem_pkg::out_item_t               m_item
);

    import nem_pkg::*;

    localparam int SIW      = $clog2(NUM_STATES);
    localparam int MV_DEPTH = NUM_STATES << SYMBOL_BITS;
    localparam int MV_AW    = SIW + SYMBOL_BITS;

    state_t                  state_reg, state_next;
    logic [MV_AW-1:0]        clr_cnt_reg, clr_cnt_next;
    logic [NUM_STATES-1:0]   cur_set_reg, cur_set_next;
    logic [NUM_STATES-1:0]   set_reg, set_next;
    logic [NUM_STATES-1:0]   pend_reg, pend_next;
    logic                    flight_reg, flight_next;
    logic                    m_valid_reg, m_valid_next;
    out_item_t               m_item_reg, m_item_next;
    in_item_t                item_reg;
    logic [4:0]              start_state_reg;
    logic [31:0]             goal_mask_reg;
    logic [7:0]              eps_code_reg;

    logic                    mv_we, ep_we;
    logic [MV_AW-1:0]        mv_waddr, mv_raddr;
    logic [SIW-1:0]          ep_waddr, ep_raddr;
    logic [NUM_STATES-1:0]   mv_wdata, ep_wdata, mv_rdata, ep_rdata;

    logic [SIW-1:0]          src_idx, dst_idx, pick_idx;
    logic [SYMBOL_BITS-1:0]  sym_idx;
    logic [NUM_STATES-1:0]   dst_bit, pick_oh, init_set;
    logic                    in_range, is_eps, s_fire;
    logic [NUM_STATES+31:0]  set_wide;

    function automatic logic [SIW-1:0] onehot_idx(input logic [NUM_STATES-1:0] oh);
        logic [SIW-1:0] idx;
        idx = '0;
        for (int i = 0; i < NUM_STATES; i++) begin
            if (oh[i]) begin
                idx = idx | SIW'(i);
            end
        end
        return idx;
    endfunction

    nem_ram #(.WIDTH(NUM_STATES), .DEPTH(MV_DEPTH)) u_move_ram (
        .aclk    (aclk),
        .wr_en   (mv_we),
        .wr_addr (mv_waddr),
        .wr_data (mv_wdata),
        .rd_addr (mv_raddr),
        .rd_data (mv_rdata)
    );

    nem_ram #(.WIDTH(NUM_STATES), .DEPTH(NUM_STATES)) u_eps_ram (
        .aclk    (aclk),
        .wr_en   (ep_we),
        .wr_addr (ep_waddr),
        .wr_data (ep_wdata),
        .rd_addr (ep_raddr),
        .rd_data (ep_rdata)
    );

    assign src_idx  = SIW'(item_reg.src_state);
    assign dst_idx  = SIW'(item_reg.dst_state);
    assign sym_idx  = item_reg.symbol[SYMBOL_BITS-1:0];
    assign in_range = (int'(item_reg.src_state) < NUM_STATES)
                   && (int'(item_reg.dst_state) < NUM_STATES);
    assign is_eps   = (item_reg.symbol == eps_code_reg);
    assign dst_bit  = NUM_STATES'(1) << dst_idx;
    assign init_set = (int'(start_state_reg) < NUM_STATES)
                    ? (NUM_STATES'(1) << SIW'(start_state_reg)) : '0;

    // lowest pending state
    assign pick_oh  = pend_reg & (~pend_reg + NUM_STATES'(1));
    assign pick_idx = onehot_idx(pick_oh);

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign set_wide = {32'b0, cur_set_reg};

    assign mv_raddr = (state_reg == ST_MOVE) ? {pick_idx, sym_idx} : {src_idx, sym_idx};
    assign ep_raddr = (state_reg == ST_CLOSE) ? pick_idx : src_idx;

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        cur_set_next = cur_set_reg;
        set_next     = set_reg;
        pend_next    = pend_reg;
        flight_next  = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        m_item_next  = m_item_reg;
        mv_we        = 1'b0;
        ep_we        = 1'b0;
        mv_waddr     = {src_idx, sym_idx};
        ep_waddr     = src_idx;
        mv_wdata     = mv_rdata | dst_bit;
        ep_wdata     = ep_rdata | dst_bit;

        unique case (state_reg)
            ST_CLEAR: begin
                mv_we        = 1'b1;
                mv_waddr     = clr_cnt_reg;
                mv_wdata     = '0;
                ep_we        = (clr_cnt_reg < MV_AW'(NUM_STATES));
                ep_waddr     = clr_cnt_reg[SIW-1:0];
                ep_wdata     = '0;
                clr_cnt_next = clr_cnt_reg + MV_AW'(1);
                if (clr_cnt_reg == MV_AW'(MV_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    priority if (s_item.kind == KIND_ADD) begin
                        state_next = ST_ADD_RD;
                    end else if (s_item.kind == KIND_BEGIN) begin
                        set_next   = init_set;
                        pend_next  = init_set;
                        state_next = ST_CLOSE;
                    end else if (s_item.kind == KIND_CONSUME) begin
                        set_next   = '0;
                        pend_next  = cur_set_reg;
                        state_next = ST_MOVE;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_ADD_RD: begin
                state_next = in_range ? ST_ADD_WR : ST_FINISH;
            end
            ST_ADD_WR: begin
                ep_we      = is_eps;
                mv_we      = !is_eps;
                state_next = ST_FINISH;
            end
            ST_MOVE: begin
                flight_next = |pend_reg;
                pend_next   = pend_reg & ~pick_oh;
                if (flight_reg) begin
                    set_next = set_reg | mv_rdata;
                end
                if (!(|pend_reg) && !flight_reg) begin
                    pend_next  = set_reg;
                    state_next = ST_CLOSE;
                end
            end
            ST_CLOSE: begin
                flight_next = |pend_reg;
                pend_next   = pend_reg & ~pick_oh;
                if (flight_reg) begin
                    set_next  = set_reg | ep_rdata;
                    pend_next = (pend_reg & ~pick_oh) | (ep_rdata & ~set_reg);
                end
                if (!(|pend_reg) && !flight_reg) begin
                    cur_set_next = set_reg;
                    state_next   = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next           = 1'b1;
                    m_item_next.active_set = set_wide[31:0];
                    m_item_next.accepted   = |(set_wide[31:0] & goal_mask_reg);
                    m_item_next.dead       = ~|cur_set_reg;
                    state_next             = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            clr_cnt_reg     <= '0;
            cur_set_reg     <= '0;
            flight_reg      <= 1'b0;
            m_valid_reg     <= 1'b0;
            start_state_reg <= '0;
            goal_mask_reg   <= '0;
            eps_code_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            cur_set_reg <= cur_set_next;
            flight_reg  <= flight_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_START_STATE:  start_state_reg <= cfg_wr_data[4:0];
                    CFG_GOAL_MASK:    goal_mask_reg   <= cfg_wr_data[31:0];
                    CFG_EPSILON_CODE: eps_code_reg    <= cfg_wr_data[7:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        set_reg    <= set_next;
        pend_reg   <= pend_next;
        m_item_reg <= m_item_next;
        if (s_fire) begin
            item_reg <= s_item;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second transaction accepted while one is in progress");

    a_pend_in_set: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLOSE) |-> ((pend_reg & ~set_reg) == '0))
        else $error("closure worklist holds a state outside the set");

    a_dead_not_accepted: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_item.dead && m_item.accepted))
        else $error("empty set reported as accepting");

    a_dead_matches_set: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (NUM_STATES <= 32) |-> (m_item.dead == (m_item.active_set == '0)))
        else $error("dead flag disagrees with active set");

endmodule
